// ----- rtl/core/mlfq_pkg.sv -----
package mlfq_pkg;

  localparam int NUM_THREADS_DEF  = 64;
  localparam int NUM_LEVELS_DEF   = 10;
  localparam int NUM_CLASSES_DEF  = 4;
  localparam int RUNTIME_BITS_DEF = 32;

  localparam int TID_W   = 6;
  localparam int CLASS_W = 2;
  localparam int BURST_W = 16;
  localparam int LEVEL_W = 4;
  localparam int SLICE_W = 10;
  localparam int RTOUT_W = 32;

  typedef enum logic {
    REQ_ENQUEUE  = 1'b0,
    REQ_DISPATCH = 1'b1
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_EXEC,
    ST_OUT
  } mlfq_state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic rd_a;
    logic rd_b;
    logic exec;
  } mlfq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_dispatch;
  } mlfq_stat_t;

endpackage

// ----- rtl/core/mlfq_if.sv -----
interface mlfq_in_if
  import mlfq_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [TID_W-1:0]     thread_id;
  logic [CLASS_W-1:0]   thread_class;
  logic [BURST_W-1:0]   burst_length;
  logic                 new_thread;

  modport source (output valid, req_type, thread_id, thread_class, burst_length, new_thread,
                  input ready);
  modport sink (input valid, req_type, thread_id, thread_class, burst_length, new_thread,
                output ready);
endinterface

interface mlfq_out_if
  import mlfq_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [TID_W-1:0]     chosen_thread;
  logic [LEVEL_W-1:0]   chosen_level;
  logic [CLASS_W-1:0]   chosen_class;
  logic [SLICE_W-1:0]   slice_ticks;
  logic [RTOUT_W-1:0]   runtime_before;

  modport source (output valid, found, chosen_thread, chosen_level, chosen_class, slice_ticks,
                  runtime_before, input ready);
  modport sink (input valid, found, chosen_thread, chosen_level, chosen_class, slice_ticks,
                runtime_before, output ready);
endinterface

// ----- rtl/core/mlfq_thread_scheduler_unit.sv -----
// channel | dir | handshake        | payload
// in_     | in  | in_valid/ready   | req_type thread_id thread_class burst_length new_thread
// out_    | out | out_valid/ready  | found chosen_thread chosen_level chosen_class
//         |     |                  | slice_ticks runtime_before
// A request is accepted in idle, then two memory read states and one update state follow.
// An enqueue returns to idle straight after the update state.
// A dispatch result is registered in the update state and held in the output state until
// out_ready; no new request is accepted before it is taken.
// rst_n is synchronous; it clears waiting flags, queue valid bits and the per-thread written
// flags that make untouched levels and runtimes read as zero.
module mlfq_thread_scheduler_unit
  import mlfq_pkg::*;
#(
  parameter int NUM_THREADS  = NUM_THREADS_DEF,
  parameter int NUM_LEVELS   = NUM_LEVELS_DEF,
  parameter int NUM_CLASSES  = NUM_CLASSES_DEF,
  parameter int RUNTIME_BITS = RUNTIME_BITS_DEF
)(
  input logic clk,
  input logic rst_n,
  mlfq_in_if.sink    in_ch,
  mlfq_out_if.source out_ch
);

  mlfq_cmd_t  cmd;
  mlfq_stat_t stat;

  mlfq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mlfq_dp #(
    .NUM_THREADS  (NUM_THREADS),
    .NUM_LEVELS   (NUM_LEVELS),
    .NUM_CLASSES  (NUM_CLASSES),
    .RUNTIME_BITS (RUNTIME_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_req_type        (in_ch.req_type),
    .in_thread_id       (in_ch.thread_id),
    .in_thread_class    (in_ch.thread_class),
    .in_burst_length    (in_ch.burst_length),
    .in_new_thread      (in_ch.new_thread),
    .out_found          (out_ch.found),
    .out_chosen_thread  (out_ch.chosen_thread),
    .out_chosen_level   (out_ch.chosen_level),
    .out_chosen_class   (out_ch.chosen_class),
    .out_slice_ticks    (out_ch.slice_ticks),
    .out_runtime_before (out_ch.runtime_before)
  );

endmodule

// ----- rtl/core/mlfq_ctrl.sv -----
module mlfq_ctrl
  import mlfq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  mlfq_stat_t stat,
  output mlfq_cmd_t  cmd
);

  mlfq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = ST_RD_A;
        end
      end
      ST_RD_A: begin
        cmd.rd_a  = 1'b1;
        state_nxt = ST_RD_B;
      end
      ST_RD_B: begin
        cmd.rd_b  = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        // captured request decides the path
        if (stat.is_dispatch) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/mlfq_dp.sv -----
module mlfq_dp
  import mlfq_pkg::*;
#(
  parameter int NUM_THREADS  = NUM_THREADS_DEF,
  parameter int NUM_LEVELS   = NUM_LEVELS_DEF,
  parameter int NUM_CLASSES  = NUM_CLASSES_DEF,
  parameter int RUNTIME_BITS = RUNTIME_BITS_DEF
)(
  input  logic               clk,
  input  logic               rst_n,
  input  mlfq_cmd_t          cmd,
  output mlfq_stat_t         stat,
  input  logic               in_req_type,
  input  logic [TID_W-1:0]   in_thread_id,
  input  logic [CLASS_W-1:0] in_thread_class,
  input  logic [BURST_W-1:0] in_burst_length,
  input  logic               in_new_thread,
  output logic               out_found,
  output logic [TID_W-1:0]   out_chosen_thread,
  output logic [LEVEL_W-1:0] out_chosen_level,
  output logic [CLASS_W-1:0] out_chosen_class,
  output logic [SLICE_W-1:0] out_slice_ticks,
  output logic [RTOUT_W-1:0] out_runtime_before
);

  localparam int NQ   = NUM_LEVELS * NUM_CLASSES;
  localparam int TW   = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
  localparam int QW   = (NQ > 1) ? $clog2(NQ) : 1;
  localparam int LW   = $clog2(NUM_LEVELS);
  localparam int CW   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int RW   = RUNTIME_BITS;
  localparam int SW   = ((RW > BURST_W) ? RW : BURST_W) + 1;

  // per-thread and per-queue memories, registered reads, no reset
  logic [LW-1:0]      lvl_r   [NUM_THREADS];
  logic [RW-1:0]      rt_r    [NUM_THREADS];
  logic [BURST_W-1:0] burst_r [NUM_THREADS];
  logic [TW-1:0]      link_r  [NUM_THREADS];
  logic [TW-1:0]      head_r  [NQ];
  logic [TW-1:0]      tail_r  [NQ];

  // flops: level/runtime written since reset, waiting, queue valid
  logic [NUM_THREADS-1:0] seen_r;
  logic [NUM_THREADS-1:0] wait_r;
  logic [NQ-1:0]          ne_r;

  logic               req_r;
  logic [TID_W-1:0]   tid_r;
  logic [CLASS_W-1:0] cls_r;
  logic [BURST_W-1:0] bl_r;
  logic               new_r;

  logic [LW-1:0]      lvl_rd_r;
  logic [RW-1:0]      rt_rd_r;
  logic               seen_rd_r;
  logic [BURST_W-1:0] burst_rd_r;
  logic [TW-1:0]      link_rd_r;
  logic [TW-1:0]      head_rd_r;
  logic [TW-1:0]      tail_rd_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_req_type;
      tid_r <= in_thread_id;
      cls_r <= in_thread_class;
      bl_r  <= in_burst_length;
      new_r <= in_new_thread;
    end
  end

  logic is_dsp;
  assign is_dsp           = (req_r == REQ_DISPATCH);
  assign stat.is_dispatch = is_dsp;

  // unwritten level/runtime entries read as zero
  logic [LW-1:0] lvl_base;
  logic [RW-1:0] rt_base;
  assign lvl_base = seen_rd_r ? lvl_rd_r : '0;
  assign rt_base  = seen_rd_r ? rt_rd_r : '0;

  // enqueue path
  logic          tid_ok;
  logic [TW-1:0] t_e;
  logic [CW-1:0] c_e;
  logic [LW-1:0] l_cur, l_new;
  logic [RW-1:0] r_cur;
  logic          demote;
  logic [QW-1:0] q_e;
  logic          do_enq;

  always_comb begin
    tid_ok = (32'(tid_r) < NUM_THREADS);
    t_e    = TW'(tid_r);
    c_e    = (32'(cls_r) >= NUM_CLASSES) ? CW'(NUM_CLASSES - 1) : CW'(cls_r);
    l_cur  = new_r ? '0 : lvl_base;
    r_cur  = new_r ? '0 : rt_base;
    if (32'(l_cur) >= NUM_LEVELS) l_cur = LW'(NUM_LEVELS - 1);
    demote = (32'(l_cur) < NUM_LEVELS - 1) &&
             ((r_cur >> l_cur) != '0);
    l_new  = demote ? l_cur + LW'(1) : l_cur;
    q_e    = QW'(32'(l_new) * NUM_CLASSES + 32'(c_e));
    do_enq = cmd.exec && !is_dsp && tid_ok && !wait_r[t_e];
  end

  // dispatch path: first non-empty queue, lowest level then lowest class
  logic [LW-1:0] l_d;
  logic [CW-1:0] c_d;
  logic          any_d;
  logic [QW-1:0] q_d;
  always_comb begin
    l_d   = '0;
    c_d   = '0;
    any_d = 1'b0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
        if (ne_r[l * NUM_CLASSES + c]) begin
          l_d   = LW'(l);
          c_d   = CW'(c);
          any_d = 1'b1;
        end
      end
    end
    q_d = QW'(32'(l_d) * NUM_CLASSES + 32'(c_d));
  end

  logic [TW-1:0] t_d;
  logic [SW-1:0] sum_d;
  logic [RW-1:0] rt_upd;
  always_comb begin
    t_d    = head_rd_r;
    sum_d  = SW'(rt_base) + SW'(burst_rd_r);
    rt_upd = ((sum_d >> RW) != '0) ? '1 : RW'(sum_d);
  end

  logic dsp_exec;
  logic do_dsp;
  assign dsp_exec = cmd.exec && is_dsp;
  assign do_dsp   = dsp_exec && any_d;

  // read ports: enqueue reads thread state then the queue tail;
  // dispatch reads head and tail then the head thread's state
  always_ff @(posedge clk) begin
    if (cmd.rd_a) begin
      if (is_dsp) begin
        head_rd_r <= head_r[q_d];
        tail_rd_r <= tail_r[q_d];
      end else begin
        lvl_rd_r  <= lvl_r[t_e];
        rt_rd_r   <= rt_r[t_e];
        seen_rd_r <= seen_r[t_e];
      end
    end else if (cmd.rd_b) begin
      if (is_dsp) begin
        rt_rd_r    <= rt_r[head_rd_r];
        seen_rd_r  <= seen_r[head_rd_r];
        burst_rd_r <= burst_r[head_rd_r];
        link_rd_r  <= link_r[head_rd_r];
      end else begin
        tail_rd_r <= tail_r[q_e];
      end
    end
  end

  // write ports
  always_ff @(posedge clk) begin
    if (do_enq) begin
      lvl_r[t_e]   <= l_new;
      rt_r[t_e]    <= demote ? '0 : r_cur;
      burst_r[t_e] <= bl_r;
      if (ne_r[q_e]) begin
        link_r[tail_rd_r] <= t_e;
      end else begin
        head_r[q_e] <= t_e;
      end
      tail_r[q_e] <= t_e;
    end else if (do_dsp) begin
      if (tail_rd_r != t_d) begin
        head_r[q_d] <= link_rd_r;
      end
      rt_r[t_d] <= rt_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      wait_r <= '0;
      ne_r   <= '0;
    end else if (do_enq) begin
      seen_r[t_e] <= 1'b1;
      wait_r[t_e] <= 1'b1;
      ne_r[q_e]   <= 1'b1;
    end else if (do_dsp) begin
      if (tail_rd_r == t_d) begin
        ne_r[q_d] <= 1'b0;
      end
      wait_r[t_d] <= 1'b0;
    end
  end

  logic [SLICE_W-1:0] slice_d;
  always_comb begin
    slice_d = '0;
    if (32'(l_d) < SLICE_W) slice_d = SLICE_W'(1) << l_d;
  end

  // hold result until taken
  always_ff @(posedge clk) begin
    if (dsp_exec) begin
      out_found          <= any_d;
      out_chosen_thread  <= any_d ? TID_W'(t_d) : '0;
      out_chosen_level   <= any_d ? LEVEL_W'(l_d) : '0;
      out_chosen_class   <= any_d ? CLASS_W'(c_d) : '0;
      out_slice_ticks    <= any_d ? slice_d : '0;
      out_runtime_before <= any_d ? RTOUT_W'(rt_base) : '0;
    end
  end

endmodule

// ----- dv/mlfq_thread_scheduler_unit_tb.sv -----
`timescale 1ns / 100ps

module mlfq_thread_scheduler_unit_tb;
  import mlfq_pkg::*;

  localparam int N_THR = 64;
  localparam int N_LVL = 10;
  localparam int N_CLS = 4;
  localparam int N_Q   = N_LVL * N_CLS;

  typedef struct packed {
    logic               found;
    logic [TID_W-1:0]   thread;
    logic [LEVEL_W-1:0] level;
    logic [CLASS_W-1:0] cls;
    logic [SLICE_W-1:0] slice;
    logic [RTOUT_W-1:0] runtime;
  } dispatch_t;

  typedef struct packed {
    req_kind_t          kind;
    logic [TID_W-1:0]   tid;
    logic [CLASS_W-1:0] cls;
    logic [BURST_W-1:0] burst;
    logic               fresh;
  } request_t;

  // directed row: request plus an optional typed-in result
  typedef struct packed {
    request_t  req;
    logic      has_exp;
    dispatch_t exp;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  mlfq_in_if  in_ch ();
  mlfq_out_if out_ch ();

  mlfq_thread_scheduler_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // scheduler shadow state
  logic [3:0]          lvl_of [N_THR];
  logic [31:0]         run_of [N_THR];
  logic [15:0]         burst_of [N_THR];
  logic                waiting [N_THR];
  int                  fifo_q [N_Q][$];

  dispatch_t           pending_dispatches [$];
  int                  mismatches = 0;
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;

  task automatic sched_reset();
    for (int t = 0; t < N_THR; t++) begin
      lvl_of[t] = '0; run_of[t] = '0; burst_of[t] = '0; waiting[t] = 1'b0;
    end
    for (int q = 0; q < N_Q; q++) fifo_q[q].delete();
  endtask

  task automatic sched_apply(input request_t r);
    dispatch_t d;
    int t, lvl, q;
    logic [32:0] sum;
    d = '0;
    if (r.kind == REQ_ENQUEUE) begin
      t = r.tid;
      if (waiting[t]) return;
      if (r.fresh) begin
        lvl_of[t] = '0; run_of[t] = '0;
      end
      lvl = lvl_of[t];
      if (lvl < N_LVL - 1 && {32'd0, run_of[t]} >= (64'd1 << lvl)) begin
        lvl++; run_of[t] = '0;
      end
      lvl_of[t] = 4'(lvl);
      burst_of[t] = r.burst;
      fifo_q[lvl * N_CLS + r.cls].push_back(t);
      waiting[t] = 1'b1;
    end else begin
      for (q = 0; q < N_Q; q++) if (fifo_q[q].size() != 0) break;
      if (q < N_Q) begin
        t = fifo_q[q].pop_front();
        waiting[t] = 1'b0;
        d.found = 1'b1;
        d.thread = TID_W'(t);
        d.level = LEVEL_W'(q / N_CLS);
        d.cls = CLASS_W'(q % N_CLS);
        d.slice = SLICE_W'(1) << (q / N_CLS);
        d.runtime = run_of[t];
        sum = {1'b0, run_of[t]} + 33'(burst_of[t]);
        run_of[t] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end
      pending_dispatches.push_back(d);
    end
  endtask

  task automatic send(input request_t r);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= r.kind;
    in_ch.thread_id <= r.tid;
    in_ch.thread_class <= r.cls;
    in_ch.burst_length <= r.burst;
    in_ch.new_thread <= r.fresh;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sched_apply(r);
    @(negedge clk);
  endtask

  function automatic request_t mk(input req_kind_t k, input int tid, input int cls,
                                  input int burst, input bit fresh);
    request_t r;
    r.kind = k; r.tid = TID_W'(tid); r.cls = CLASS_W'(cls); r.burst = BURST_W'(burst);
    r.fresh = fresh;
    return r;
  endfunction

  function automatic request_t rand_req(input int tid_span);
    request_t r;
    r.kind = ($urandom_range(99) < 45) ? REQ_DISPATCH : REQ_ENQUEUE;
    r.tid = TID_W'($urandom_range(tid_span));
    r.cls = CLASS_W'($urandom_range(3));
    case ($urandom_range(3))
      0: r.burst = 16'hFFFF;
      1: r.burst = BURST_W'($urandom_range(3));
      default: r.burst = BURST_W'($urandom);
    endcase
    r.fresh = ($urandom_range(9) == 0);
    return r;
  endfunction

  // receiver: random stall, compare each accepted dispatch
  always @(negedge clk) begin
    out_ch.ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    dispatch_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.found, out_ch.chosen_thread, out_ch.chosen_level, out_ch.chosen_class,
             out_ch.slice_ticks, out_ch.runtime_before};
      if (pending_dispatches.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected dispatch result %p", got);
      end else begin
        want = pending_dispatches.pop_front();
        if (got.found !== want.found || got.thread !== want.thread ||
            got.level !== want.level || got.cls !== want.cls ||
            got.slice !== want.slice || got.runtime !== want.runtime) begin
          mismatches++;
          if (mismatches <= 10) $display("dispatch mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("mlfq_thread_scheduler_unit_tb: errors");
    $finish;
  end

  initial begin
    row_t rows [$];
    row_t rw;
    dispatch_t typed;
    int limit;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_ENQUEUE;
    in_ch.thread_id = '0;
    in_ch.thread_class = '0;
    in_ch.burst_length = '0;
    in_ch.new_thread = 1'b0;
    sched_reset();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    rw = '0; rw.req = mk(REQ_DISPATCH, 0, 0, 0, 0); rw.has_exp = 1'b1; rows.push_back(rw);
    rw = '0; rw.req = mk(REQ_ENQUEUE, 63, 3, 16'hFFFF, 1); rows.push_back(rw);
    rw = '0; rw.req = mk(REQ_ENQUEUE, 0, 0, 0, 0); rows.push_back(rw);
    rw = '0; rw.req = mk(REQ_ENQUEUE, 5, 1, 7, 0); rows.push_back(rw);
    rw = '0; rw.req = mk(REQ_ENQUEUE, 6, 1, 9, 0); rows.push_back(rw);
    rw = '0; rw.req = mk(REQ_ENQUEUE, 5, 2, 1, 1); rows.push_back(rw);   // already waiting
    rw = '0; rw.req = mk(REQ_ENQUEUE, 12, 2, 16'hAAAA, 0); rows.push_back(rw);
    typed = '{1'b1, 6'd0, 4'd0, 2'd0, 10'd1, 32'd0};
    rw = '0; rw.req = mk(REQ_DISPATCH, 0, 0, 0, 0); rw.has_exp = 1'b1; rw.exp = typed;
    rows.push_back(rw);
    for (int i = 0; i < 4; i++) begin
      rw = '0; rw.req = mk(REQ_DISPATCH, 0, 0, 0, 0); rows.push_back(rw);
    end
    rw = '0; rw.req = mk(REQ_DISPATCH, 0, 0, 0, 0); rw.has_exp = 1'b1; rows.push_back(rw);
    // thread 63 ran 0xFFFF: demote it once on re-enqueue, then dispatch it from level 1
    rw = '0; rw.req = mk(REQ_ENQUEUE, 63, 3, 16'hFFFF, 0); rows.push_back(rw);
    rw = '0; rw.req = mk(REQ_DISPATCH, 0, 0, 0, 0); rows.push_back(rw);
    rw = '0; rw.req = mk(REQ_ENQUEUE, 6, 0, 16'h5555, 0); rows.push_back(rw);
    rw = '0; rw.req = mk(REQ_DISPATCH, 0, 0, 0, 0); rows.push_back(rw);
    foreach (rows[i]) begin
      send(rows[i].req);
      if (rows[i].has_exp) pending_dispatches[pending_dispatches.size() - 1] = rows[i].exp;
    end

    // push one thread to the last level and keep it there
    for (int k = 0; k < 16; k++) begin
      send(mk(REQ_ENQUEUE, 40, k % 4, 16'hFFFF, 0));
      send(mk(REQ_DISPATCH, 0, 0, 0, 0));
    end

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 16 : 46) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 16 : 46) : 0;
      for (int i = 0; i < 425; i++) begin
        send(rand_req((i % 3 == 0) ? 63 : 11));
        if (i == 200) begin
          // hold until every dispatch has come back
          in_ch.valid <= 1'b0;
          wait (pending_dispatches.size() == 0);
          @(negedge clk);
        end
      end
    end
    send_idle_pct = 0;
    in_ch.valid <= 1'b0;

    limit = 0;
    while (pending_dispatches.size() != 0 && limit < 100000) begin
      @(posedge clk); limit++;
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_dispatches.size() == 0)
      $display("mlfq_thread_scheduler_unit_tb: clean");
    else
      $display("mlfq_thread_scheduler_unit_tb: errors");
    $finish;
  end

endmodule
